// ===== src/trre_pkg.sv =====
package trre_pkg;

    // Table sizes
    localparam int unsigned RULE_COUNT   = 64;
    localparam int unsigned SENSOR_COUNT = 5;
    localparam int unsigned RELAY_COUNT  = 8;

    // Fixed field widths
    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned RELAY_OUT_W = 8;

    // Item modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_EVAL  = 2'd2;
    localparam logic [1:0] MODE_SET   = 2'd3;

    // Compare codes; the rest never match
    localparam logic [2:0] CMP_EQ = 3'd0;
    localparam logic [2:0] CMP_GE = 3'd1;
    localparam logic [2:0] CMP_LE = 3'd2;
    localparam logic [2:0] CMP_GT = 3'd3;
    localparam logic [2:0] CMP_LT = 3'd4;

    typedef logic [VALUE_W-1:0] value_t;
    typedef value_t [SENSOR_COUNT-1:0] sensor_bank_t;
    typedef logic [RELAY_COUNT-1:0] relay_vec_t;

    // One stored rule
    typedef struct packed {
        logic         enable;
        logic [2:0]   sensor;
        value_t       limit;
        logic [2:0]   kind;
        logic [2:0]   relay;
        logic         action;
    } rule_t;

    // Relay vector handed from cell to cell during an evaluation
    typedef struct packed {
        logic       valid;
        relay_vec_t relays;
    } token_t;

    // Signed compare of a sensor word against a rule limit
    function automatic logic cmp_hit(input logic [2:0] kind, input value_t s, input value_t lim);
        logic hit;
        unique case (kind)
            CMP_EQ:  hit = ($signed(s) == $signed(lim));
            CMP_GE:  hit = ($signed(s) >= $signed(lim));
            CMP_LE:  hit = ($signed(s) <= $signed(lim));
            CMP_GT:  hit = ($signed(s) >  $signed(lim));
            CMP_LT:  hit = ($signed(s) <  $signed(lim));
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Force one relay bit; an index past the vector changes nothing
    function automatic relay_vec_t drive_relay(input relay_vec_t v, input logic [2:0] idx,
                                               input logic on);
        relay_vec_t r;
        r = v;
        for (int k = 0; k < int'(RELAY_COUNT); k++) begin
            if (32'(idx) == k) begin
                r[k] = on;
            end
        end
        return r;
    endfunction

endpackage

// ===== src/threshold_rule_relay_engine.sv =====
// Write rule, load sensor, manual set: result strobe in the cycle after acceptance,
// one item per cycle. The receiver cannot stall; done marks each result for one cycle.
// Evaluate: the relay vector walks the row of RULE_COUNT rule cells one cell per clock;
// result strobe once the vector leaves the last cell, and busy drops in that same cycle;
// no new item is taken while busy, and the next one can be taken with the strobe.
// Reset (async, active low): all rules disabled, sensors zero, relays released.
module threshold_rule_relay_engine
    import trre_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               mode,
    input  logic [5:0]               rule_index,
    input  logic                     rule_enable,
    input  logic [2:0]               sensor_select,
    input  logic signed [31:0]       threshold,
    input  logic [2:0]               compare_kind,
    input  logic [2:0]               relay_index,
    input  logic                     relay_action,
    input  logic signed [31:0]       sensor_value,
    output logic                     done,
    output logic [RELAY_OUT_W-1:0]   relay_states
);

    logic                   busy_reg;
    logic                   done_reg;
    logic [RELAY_OUT_W-1:0] states_reg;
    relay_vec_t             relay_reg;
    relay_vec_t             relay_next;
    sensor_bank_t           sensor_reg;
    logic                   accept;
    rule_t                  wr_rule;
    logic [RULE_COUNT-1:0]  wr_sel;
    logic [RULE_COUNT-1:0]  tok_valids;
    token_t                 tok [RULE_COUNT+1];
    token_t                 tok_last;

    assign accept = start && !busy_reg;

    // Rule word from the item fields
    always_comb
    begin
        wr_rule.enable = rule_enable;
        wr_rule.sensor = sensor_select;
        wr_rule.limit  = value_t'(threshold);
        wr_rule.kind   = compare_kind;
        wr_rule.relay  = relay_index;
        wr_rule.action = relay_action;
    end

    // Slot select for rule writes
    always_comb
    begin
        for (int i = 0; i < int'(RULE_COUNT); i++) begin
            wr_sel[i] = accept && (mode == MODE_WRITE) && (32'(rule_index) == i);
        end
    end

    // Evaluation enters the row at cell 0
    assign tok[0].valid  = accept && (mode == MODE_EVAL);
    assign tok[0].relays = relay_reg;

    for (genvar g = 0; g < int'(RULE_COUNT); g++) begin : g_cell
        trre_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (wr_sel[g]),
            .wr_rule (wr_rule),
            .sensors (sensor_reg),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
        assign tok_valids[g] = tok[g+1].valid;
    end

    assign tok_last = tok[RULE_COUNT];

    // Sensor store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sensor_reg <= '0;
        end else if (accept && (mode == MODE_LOAD)) begin
            for (int k = 0; k < int'(SENSOR_COUNT); k++) begin
                if (32'(sensor_select) == k) begin
                    sensor_reg[k] <= value_t'(sensor_value);
                end
            end
        end
    end

    // Next relay vector: the word leaving the rule row, or a manual set that finishes at once
    always_comb
    begin
        relay_next = relay_reg;
        if (tok_last.valid) begin
            relay_next = tok_last.relays;
        end else if (accept && (mode == MODE_SET)) begin
            relay_next = drive_relay(relay_reg, relay_index, relay_action);
        end
    end

    // Relay state, busy flag and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            relay_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            relay_reg <= relay_next;
            done_reg  <= tok_last.valid || (accept && (mode != MODE_EVAL));
            if (tok_last.valid) begin
                busy_reg <= 1'b0;
            end else if (accept && (mode == MODE_EVAL)) begin
                busy_reg <= 1'b1;
            end
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        states_reg <= RELAY_OUT_W'(relay_next);
    end

    assign busy         = busy_reg;
    assign done         = done_reg;
    assign relay_states = states_reg;

`ifndef ASSERT_OFF
    // Items that need no walk report in the next cycle
    a_quick_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (mode != MODE_EVAL) |=> done)
        else $error("quick item gave no result");

    // An evaluation holds the block busy
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (mode == MODE_EVAL) |=> busy && !done)
        else $error("evaluation did not raise busy");

    // At most one relay word walks the row
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valids))
        else $error("more than one word in the rule row");

    // The walk only runs while busy
    a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valids != '0) |-> busy_reg)
        else $error("rule row active while idle");
`endif

endmodule

// ===== src/trre_cell.sv =====
module trre_cell
    import trre_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  rule_t        wr_rule,
    input  sensor_bank_t sensors,
    input  token_t       tok_in,
    output token_t       tok_out
);

    logic       enable_reg;
    rule_t      rule_reg;
    logic       tok_valid_reg;
    relay_vec_t tok_relays_reg;
    value_t     sel_value;
    logic       sensor_ok;
    logic       hit;
    relay_vec_t relays_next;

    // Rule slot: enable is control, the rest is payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            enable_reg <= 1'b0;
        end else if (wr_en) begin
            enable_reg <= wr_rule.enable;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            rule_reg <= wr_rule;
        end
    end

    // Pick this rule's sensor word
    always_comb
    begin
        sel_value = '0;
        sensor_ok = 1'b0;
        for (int k = 0; k < int'(SENSOR_COUNT); k++) begin
            if (32'(rule_reg.sensor) == k) begin
                sel_value = sensors[k];
                sensor_ok = 1'b1;
            end
        end
    end

    // Apply the rule to the passing relay vector
    always_comb
    begin
        hit = enable_reg && sensor_ok && cmp_hit(rule_reg.kind, sel_value, rule_reg.limit);
        relays_next = tok_in.relays;
        if (hit) begin
            relays_next = drive_relay(tok_in.relays, rule_reg.relay, rule_reg.action);
        end
    end

    // Hand the word to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tok_valid_reg <= 1'b0;
        end else begin
            tok_valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_relays_reg <= relays_next;
    end

    assign tok_out.valid  = tok_valid_reg;
    assign tok_out.relays = tok_relays_reg;

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import trre_pkg::*;

    // Compare codes that never match
    localparam logic [2:0] CMP_NONE_FIRST = 3'd5;
    localparam logic [2:0] CMP_NONE_LAST  = 3'd7;

    localparam int ITEM_TARGET  = 1650;
    localparam int CALM_TAIL    = 200;
    localparam int DRAIN_CYCLES = RULE_COUNT + 8;
    localparam int DRAIN_GUARD  = 1000;
    localparam int REPORT_LIMIT = 10;

    // One command word as it appears on the input ports
    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] rule_index;
        logic       rule_enable;
        logic [2:0] sensor_select;
        value_t     threshold;
        logic [2:0] compare_kind;
        logic [2:0] relay_index;
        logic       relay_action;
        value_t     sensor_value;
    } word_t;

    // Tracks rule table, sensor store and relays; holds the relay words still due
    class relay_scoreboard;
        rule_t      rules[RULE_COUNT];
        value_t     sensors[SENSOR_COUNT];
        relay_vec_t relays;
        relay_vec_t expected_relays[$];
        int         errors;

        function new();
            foreach (rules[i]) rules[i] = '0;
            foreach (sensors[i]) sensors[i] = '0;
            relays = '0;
            errors = 0;
        endfunction

        // Signed test of one rule against its sensor
        function bit rule_fires(rule_t r);
            logic signed [31:0] s;
            logic signed [31:0] lim;
            if (!r.enable || r.sensor >= SENSOR_COUNT)
                return 1'b0;
            s   = sensors[r.sensor];
            lim = r.limit;
            case (r.kind)
                CMP_EQ:  return s == lim;
                CMP_GE:  return s >= lim;
                CMP_LE:  return s <= lim;
                CMP_GT:  return s > lim;
                CMP_LT:  return s < lim;
                default: return 1'b0;
            endcase
        endfunction

        function void set_relay(logic [2:0] idx, logic on);
            if (idx < RELAY_COUNT)
                relays[idx] = on;
        endfunction

        // Apply an accepted word and queue the relay vector it leaves behind
        function void note_word(word_t w);
            case (w.mode)
                MODE_WRITE:
                begin
                    if (w.rule_index < RULE_COUNT)
                        rules[w.rule_index] = {w.rule_enable, w.sensor_select, w.threshold,
                                               w.compare_kind, w.relay_index, w.relay_action};
                end
                MODE_LOAD:
                begin
                    if (w.sensor_select < SENSOR_COUNT)
                        sensors[w.sensor_select] = w.sensor_value;
                end
                MODE_EVAL:
                begin
                    // index order, so a later rule overrides an earlier one
                    foreach (rules[i])
                        if (rule_fires(rules[i]))
                            set_relay(rules[i].relay, rules[i].action);
                end
                default:
                    set_relay(w.relay_index, w.relay_action);
            endcase
            expected_relays.push_back(relays);
        endfunction

        function void check_word(relay_vec_t got);
            relay_vec_t want;
            if (expected_relays.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected relay word %b at %0t", got, $time);
                return;
            end
            want = expected_relays.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("relay_states mismatch at %0t: expected %b, got %b",
                             $time, want, got);
            end
        endfunction

        function int pending();
            return expected_relays.size();
        endfunction
    endclass

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               start         = 1'b0;
    logic               busy;
    logic [1:0]         mode          = '0;
    logic [5:0]         rule_index    = '0;
    logic               rule_enable   = 1'b0;
    logic [2:0]         sensor_select = '0;
    logic signed [31:0] threshold     = '0;
    logic [2:0]         compare_kind  = '0;
    logic [2:0]         relay_index   = '0;
    logic               relay_action  = 1'b0;
    logic signed [31:0] sensor_value  = '0;
    logic               done;
    logic [RELAY_OUT_W-1:0] relay_states;

    relay_scoreboard sb = new();

    value_t value_pool[8];
    int     sent = 0;

    threshold_rule_relay_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .rule_index    (rule_index),
        .rule_enable   (rule_enable),
        .sensor_select (sensor_select),
        .threshold     (threshold),
        .compare_kind  (compare_kind),
        .relay_index   (relay_index),
        .relay_action  (relay_action),
        .sensor_value  (sensor_value),
        .done          (done),
        .relay_states  (relay_states)
    );

    always #1 clk = ~clk;

    // Watch both sides; results first, since none belongs to a word taken at this edge
    always @(posedge clk)
    begin
        word_t seen;
        seen = {mode, rule_index, rule_enable, sensor_select, threshold,
                compare_kind, relay_index, relay_action, sensor_value};
        if (rst_n)
        begin
            if (done)
                sb.check_word(relay_states);
            if (start && !busy)
                sb.note_word(seen);
        end
    end

    // Idle stretches: none in every third block of 150 words, none in the tail
    function automatic bit calm_now();
        return (sent >= ITEM_TARGET - CALM_TAIL) || ((sent / 150) % 3 == 2);
    endfunction

    // Present one word, hold it until taken, then maybe go idle for a burst
    task automatic send_word(input word_t w);
        mode          <= w.mode;
        rule_index    <= w.rule_index;
        rule_enable   <= w.rule_enable;
        sensor_select <= w.sensor_select;
        threshold     <= w.threshold;
        compare_kind  <= w.compare_kind;
        relay_index   <= w.relay_index;
        relay_action  <= w.relay_action;
        sensor_value  <= w.sensor_value;
        start         <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        if (!calm_now() && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Stop sending and wait for every outstanding relay word
    task automatic settle();
        int guard;
        guard = 0;
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    function automatic word_t mk(logic [1:0] m, logic [5:0] idx, logic en, logic [2:0] sel,
                                 value_t thr, logic [2:0] kind, logic [2:0] rly, logic act,
                                 value_t val);
        return {m, idx, en, sel, thr, kind, rly, act, val};
    endfunction

    // Every field random, the mode too
    function automatic word_t noise_word();
        logic [127:0] raw;
        word_t        w;
        raw = {$urandom, $urandom, $urandom, $urandom};
        w   = raw[$bits(word_t)-1:0];
        return w;
    endfunction

    // Values cluster on the current pool so that compares land on both sides
    function automatic value_t pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return $urandom;
            3:       return value_pool[$urandom_range(0, 7)] + 1;
            4:       return value_pool[$urandom_range(0, 7)] - 1;
            default: return value_pool[$urandom_range(0, 7)];
        endcase
    endfunction

    function automatic void refill_pool();
        foreach (value_pool[i])
            value_pool[i] = ($urandom_range(0, 3) == 0) ? value_t'($urandom)
                                                        : value_t'($urandom_range(0, 400) - 200);
    endfunction

    // Well-formed word of a given mode; unused fields keep random junk
    function automatic word_t shaped_word(logic [1:0] m);
        word_t w;
        w = noise_word();
        w.mode = m;
        case (m)
            MODE_WRITE:
            begin
                w.rule_enable   = ($urandom_range(0, 4) != 0);
                w.sensor_select = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                              : 3'($urandom_range(0, SENSOR_COUNT-1));
                w.threshold     = pick_value();
                w.compare_kind  = ($urandom_range(0, 11) == 0)
                                  ? 3'($urandom_range(CMP_NONE_FIRST, CMP_NONE_LAST))
                                  : 3'($urandom_range(CMP_EQ, CMP_LT));
            end
            MODE_LOAD:
            begin
                w.sensor_select = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                              : 3'($urandom_range(0, SENSOR_COUNT-1));
                w.sensor_value  = pick_value();
            end
            default:
            begin
            end
        endcase
        return w;
    endfunction

    initial
    begin
        int     n;
        int     pick;
        bit     paused;
        paused = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: relays clear after reset, extremes, every compare, ignored cases
        send_word(mk(MODE_EVAL,  6'd0,  1'b1, 3'd0, 32'h0, CMP_EQ, 3'd0, 1'b1, 32'h0));
        send_word(mk(MODE_LOAD,  6'd0,  1'b0, 3'd0, 32'hffff_ffff, CMP_EQ, 3'd7, 1'b1,
                     32'h7fff_ffff));
        send_word(mk(MODE_LOAD,  6'd63, 1'b1, 3'd4, 32'h0, CMP_LT, 3'd0, 1'b0,
                     32'h8000_0000));
        // load into a sensor past the store is dropped
        send_word(mk(MODE_LOAD,  6'd0,  1'b0, 3'd7, 32'h0, CMP_EQ, 3'd0, 1'b0, 32'd5));
        send_word(mk(MODE_LOAD,  6'd0,  1'b0, 3'd1, 32'h0, CMP_EQ, 3'd0, 1'b0, 32'h0));
        send_word(mk(MODE_WRITE, 6'd0,  1'b1, 3'd0, 32'h7fff_ffff, CMP_EQ, 3'd0, 1'b1, 32'h0));
        send_word(mk(MODE_WRITE, 6'd1,  1'b1, 3'd4, 32'h8000_0000, CMP_LE, 3'd1, 1'b1, 32'h0));
        send_word(mk(MODE_WRITE, 6'd2,  1'b1, 3'd1, 32'hffff_ffff, CMP_GT, 3'd2, 1'b1, 32'h0));
        send_word(mk(MODE_WRITE, 6'd3,  1'b1, 3'd1, 32'd1, CMP_LT, 3'd3, 1'b1, 32'h0));
        send_word(mk(MODE_WRITE, 6'd4,  1'b1, 3'd0, 32'h8000_0000, CMP_GE, 3'd7, 1'b1, 32'h0));
        // rule on a sensor past the store never fires
        send_word(mk(MODE_WRITE, 6'd5,  1'b1, 3'd7, 32'h8000_0000, CMP_GE, 3'd4, 1'b1, 32'h0));
        // unknown compare codes never fire
        send_word(mk(MODE_WRITE, 6'd6,  1'b1, 3'd1, 32'h0, CMP_NONE_FIRST, 3'd5, 1'b1, 32'h0));
        send_word(mk(MODE_WRITE, 6'd7,  1'b1, 3'd1, 32'h0, CMP_NONE_LAST, 3'd6, 1'b1, 32'h0));
        // top slot overrides slot 0 on the same relay
        send_word(mk(MODE_WRITE, 6'd63, 1'b1, 3'd1, 32'h0, CMP_EQ, 3'd0, 1'b0, 32'h0));
        // disabled rule is skipped
        send_word(mk(MODE_WRITE, 6'd62, 1'b0, 3'd1, 32'h0, CMP_EQ, 3'd6, 1'b1, 32'h0));
        send_word(mk(MODE_EVAL,  6'd0,  1'b0, 3'd0, 32'h0, CMP_EQ, 3'd0, 1'b0, 32'h0));
        send_word(mk(MODE_SET,   6'd0,  1'b0, 3'd0, 32'h0, CMP_EQ, 3'd5, 1'b1, 32'h0));
        send_word(mk(MODE_SET,   6'd0,  1'b0, 3'd0, 32'h0, CMP_EQ, 3'd7, 1'b0, 32'h0));
        send_word(mk(MODE_SET,   6'd0,  1'b0, 3'd0, 32'h0, CMP_EQ, 3'd0, 1'b1, 32'h0));
        send_word(mk(MODE_EVAL,  6'd0,  1'b0, 3'd0, 32'h0, CMP_EQ, 3'd0, 1'b0, 32'h0));
        settle();

        // Random episodes: fresh values, one to six updates, then an evaluation; some are raw noise
        while (sent < ITEM_TARGET)
        begin
            if (!paused && sent >= ITEM_TARGET / 2)
            begin
                settle();
                paused = 1'b1;
            end
            refill_pool();
            n = $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0)
            begin
                // broken episode: raw noise words
                repeat (n) send_word(noise_word());
            end
            else
            begin
                repeat (n)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 5)
                        send_word(shaped_word(MODE_WRITE));
                    else if (pick < 8)
                        send_word(shaped_word(MODE_LOAD));
                    else
                        send_word(shaped_word(MODE_SET));
                end
                send_word(shaped_word(MODE_EVAL));
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hard stop well past the slowest passing run
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
